>>> sv/srs_pkg.sv
package srs_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT     = 2'd2;

    localparam logic [8:0] FRAME_COUNT_RST = 9'd8;
    localparam logic [4:0] WINDOW_SIZE_RST = 5'd4;
    localparam logic [7:0] TIMEOUT_RST     = 8'd5;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_ACK  = 1'b1;

    // result codes
    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_RETX    = 3'd1;
    localparam logic [2:0] KIND_DONE    = 3'd2;
    localparam logic [2:0] KIND_ACK_OK  = 3'd3;
    localparam logic [2:0] KIND_ACK_IGN = 3'd4;

    // at most this many transmissions are reported per tick
    localparam int REPORT_LIMIT = 16;
    localparam int RPT_W        = 5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] ack_frame;
    } req_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] frame_id;
        logic [7:0] send_count;
        logic [8:0] acked_total;
        logic       all_acked;
        logic       last;
    } rsp_t;

    // per-frame record held in the frame memory
    typedef struct packed {
        logic       acked;
        logic [7:0] timer;
        logic [7:0] tx_count;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACK_RD,
        ST_ACK_CHK,
        ST_BASE_RD,
        ST_BASE_CHK,
        ST_SEND,
        ST_TMR_RD,
        ST_TMR_CHK,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic req_take;
        logic clr_step;
        logic base_rd;
        logic base_adv;
        logic send;
        logic tmr_start;
        logic tmr_rd;
        logic tmr_step;
        logic ack_rd;
        logic ack_commit;
        logic done_emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
        logic lu_done;
        logic ent_acked;
        logic can_send;
        logic rpt_full;
        logic scan_done;
        logic need_tx;
    } sts_t;

endpackage

>>> sv/srs_ram.sv
module srs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/srs_ctrl.sv
module srs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_type,
    output logic          req_ready,
    input  srs_pkg::sts_t sts,
    output srs_pkg::cmd_t cmd
);

    srs_pkg::state_t state_reg;
    srs_pkg::state_t state_next;

    // state register; reset starts the memory clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srs_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = srs_pkg::ST_IDLE;
                end
            end
            srs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_type == srs_pkg::REQ_ACK) ? srs_pkg::ST_ACK_RD
                                                                : srs_pkg::ST_BASE_RD;
                end
            end
            srs_pkg::ST_ACK_RD:
            begin
                state_next = srs_pkg::ST_ACK_CHK;
            end
            srs_pkg::ST_ACK_CHK:
            begin
                if (sts.out_free)
                begin
                    state_next = srs_pkg::ST_IDLE;
                end
            end
            srs_pkg::ST_BASE_RD:
            begin
                state_next = sts.lu_done ? srs_pkg::ST_SEND : srs_pkg::ST_BASE_CHK;
            end
            srs_pkg::ST_BASE_CHK:
            begin
                state_next = sts.ent_acked ? srs_pkg::ST_BASE_RD : srs_pkg::ST_SEND;
            end
            srs_pkg::ST_SEND:
            begin
                if (!sts.can_send)
                begin
                    state_next = srs_pkg::ST_TMR_RD;
                end
            end
            srs_pkg::ST_TMR_RD:
            begin
                state_next = sts.scan_done ? srs_pkg::ST_DONE : srs_pkg::ST_TMR_CHK;
            end
            srs_pkg::ST_TMR_CHK:
            begin
                if (!sts.need_tx || sts.out_free || sts.rpt_full)
                begin
                    state_next = srs_pkg::ST_TMR_RD;
                end
            end
            srs_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = srs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srs_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            srs_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            srs_pkg::ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.req_take = req_valid;
            end
            srs_pkg::ST_ACK_RD:
            begin
                cmd.ack_rd = 1'b1;
            end
            srs_pkg::ST_ACK_CHK:
            begin
                cmd.ack_commit = sts.out_free;
            end
            srs_pkg::ST_BASE_RD:
            begin
                cmd.base_rd = !sts.lu_done;
            end
            srs_pkg::ST_BASE_CHK:
            begin
                cmd.base_adv = sts.ent_acked;
            end
            srs_pkg::ST_SEND:
            begin
                cmd.send      = sts.can_send && (sts.out_free || sts.rpt_full);
                cmd.tmr_start = !sts.can_send;
            end
            srs_pkg::ST_TMR_RD:
            begin
                cmd.tmr_rd = !sts.scan_done;
            end
            srs_pkg::ST_TMR_CHK:
            begin
                cmd.tmr_step = !sts.need_tx || sts.out_free || sts.rpt_full;
            end
            srs_pkg::ST_DONE:
            begin
                cmd.done_emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/srs_dp.sv
module srs_dp #(
    parameter int FRAME_COUNT_MAX = 256,
    parameter int WINDOW_MAX      = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [srs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [srs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  srs_pkg::req_t                    req,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output srs_pkg::rsp_t                    rsp,
    input  srs_pkg::cmd_t                    cmd,
    output srs_pkg::sts_t                    sts
);

    localparam int IW      = $clog2(FRAME_COUNT_MAX);
    localparam int CW      = $clog2(FRAME_COUNT_MAX + 1);
    localparam int WW      = $clog2(WINDOW_MAX + 1);
    localparam int SW      = ((CW > WW) ? CW : WW) + 1;
    localparam int ENTRY_W = $bits(srs_pkg::entry_t);

    // configuration
    logic [8:0] frame_count_reg;
    logic [4:0] window_size_reg;
    logic [7:0] timeout_reg;

    // sender state
    logic [CW-1:0]             lu_reg;     // lowest frame not known to be acked
    logic [CW-1:0]             nnf_reg;    // next new frame
    logic [CW-1:0]             acked_reg;
    logic [CW-1:0]             scan_reg;   // clear pass / timer pass index
    logic [7:0]                ack_frame_reg;
    logic [srs_pkg::RPT_W-1:0] rpt_reg;
    srs_pkg::rsp_t             rsp_reg;
    srs_pkg::rsp_t             rsp_next;
    logic                      rsp_valid_reg;
    logic                      rsp_load;

    logic [CW-1:0] nf;
    logic [WW-1:0] win;
    logic [CW-1:0] base;
    logic [CW-1:0] scan_end;
    logic [SW-1:0] win_end;
    logic          can_send;
    logic          out_free;
    logic          rpt_full;
    logic          need_upd;
    logic          need_tx;
    logic          ack_ok;
    logic [7:0]    tmr_dec;
    logic [7:0]    cnt_inc;
    logic [CW-1:0] acked_now;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    srs_pkg::entry_t      ram_wdata;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    srs_pkg::entry_t      ent;

    srs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(FRAME_COUNT_MAX)
    ) u_frames (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign ent = srs_pkg::entry_t'(ram_rdata);

    // effective frame count and window
    always_comb
    begin
        if (32'(frame_count_reg) > FRAME_COUNT_MAX)
        begin
            nf = CW'(FRAME_COUNT_MAX);
        end
        else
        begin
            nf = CW'(frame_count_reg);
        end
        if (32'(window_size_reg) > WINDOW_MAX)
        begin
            win = WW'(WINDOW_MAX);
        end
        else
        begin
            win = WW'(window_size_reg);
        end
    end

    // window bounds; frames below lu_reg are all acked
    assign base     = (lu_reg < nf) ? lu_reg : nf;
    assign scan_end = (nnf_reg < nf) ? nnf_reg : nf;
    assign win_end  = SW'(base) + SW'(win);
    assign can_send = (nnf_reg < nf) && (SW'(nnf_reg) < win_end);

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign rpt_full = rpt_reg >= srs_pkg::RPT_W'(srs_pkg::REPORT_LIMIT);

    // timer update of the entry under scan
    assign need_upd = !ent.acked && (ent.timer != 8'd0);
    assign need_tx  = need_upd && (ent.timer == 8'd1);
    assign tmr_dec  = ent.timer - 8'd1;
    assign cnt_inc  = (ent.tx_count == 8'hFF) ? ent.tx_count : ent.tx_count + 8'd1;

    // ack validity: in range, already sent, not yet acked
    assign ack_ok = (32'(ack_frame_reg) < 32'(nf)) && (32'(ack_frame_reg) < 32'(nnf_reg))
                    && !ent.acked;

    assign acked_now = (cmd.ack_commit && ack_ok) ? acked_reg + 1'b1 : acked_reg;

    // read port select
    always_comb
    begin
        ram_re = cmd.ack_rd || cmd.base_rd || cmd.tmr_rd;
        priority if (cmd.ack_rd)
        begin
            ram_raddr = IW'(ack_frame_reg);
        end
        else if (cmd.base_rd)
        begin
            ram_raddr = lu_reg[IW-1:0];
        end
        else
        begin
            ram_raddr = scan_reg[IW-1:0];
        end
    end

    // write port select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = scan_reg[IW-1:0];
        ram_wdata = '0;
        priority if (cmd.clr_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.send)
        begin
            ram_we             = 1'b1;
            ram_waddr          = nnf_reg[IW-1:0];
            ram_wdata.timer    = timeout_reg;
            ram_wdata.tx_count = 8'd1;
        end
        else if (cmd.tmr_step)
        begin
            ram_we             = need_upd;
            ram_wdata.timer    = need_tx ? timeout_reg : tmr_dec;
            ram_wdata.tx_count = need_tx ? cnt_inc : ent.tx_count;
        end
        else if (cmd.ack_commit)
        begin
            ram_we             = ack_ok;
            ram_waddr          = IW'(ack_frame_reg);
            ram_wdata.acked    = 1'b1;
            ram_wdata.tx_count = ent.tx_count;
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    // result select
    always_comb
    begin
        rsp_load             = 1'b0;
        rsp_next.kind        = srs_pkg::KIND_DONE;
        rsp_next.frame_id    = 8'd0;
        rsp_next.send_count  = 8'd0;
        rsp_next.acked_total = 9'(acked_now);
        rsp_next.all_acked   = acked_now >= nf;
        rsp_next.last        = 1'b1;
        priority if (cmd.send)
        begin
            rsp_load            = !rpt_full;
            rsp_next.kind       = srs_pkg::KIND_SEND;
            rsp_next.frame_id   = 8'(nnf_reg);
            rsp_next.send_count = 8'd1;
            rsp_next.last       = 1'b0;
        end
        else if (cmd.tmr_step)
        begin
            rsp_load            = need_tx && !rpt_full;
            rsp_next.kind       = srs_pkg::KIND_RETX;
            rsp_next.frame_id   = 8'(scan_reg);
            rsp_next.send_count = cnt_inc;
            rsp_next.last       = 1'b0;
        end
        else if (cmd.ack_commit)
        begin
            rsp_load            = 1'b1;
            rsp_next.kind       = ack_ok ? srs_pkg::KIND_ACK_OK : srs_pkg::KIND_ACK_IGN;
            rsp_next.frame_id   = ack_frame_reg;
            rsp_next.send_count = ack_ok ? ent.tx_count : 8'd0;
        end
        else if (cmd.done_emit)
        begin
            rsp_load = 1'b1;
        end
        else
        begin
            rsp_load = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= srs_pkg::FRAME_COUNT_RST;
            window_size_reg <= srs_pkg::WINDOW_SIZE_RST;
            timeout_reg     <= srs_pkg::TIMEOUT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                srs_pkg::REG_FRAME_COUNT: frame_count_reg <= cfg_wdata;
                srs_pkg::REG_WINDOW_SIZE: window_size_reg <= cfg_wdata[4:0];
                srs_pkg::REG_TIMEOUT:     timeout_reg     <= cfg_wdata[7:0];
                default:                  ;
            endcase
        end
    end

    // counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lu_reg        <= '0;
            nnf_reg       <= '0;
            acked_reg     <= '0;
            scan_reg      <= '0;
            rpt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.base_adv)
            begin
                lu_reg <= lu_reg + 1'b1;
            end
            if (cmd.send)
            begin
                nnf_reg <= nnf_reg + 1'b1;
            end
            acked_reg <= acked_now;
            if (cmd.tmr_start)
            begin
                scan_reg <= base;
            end
            else if (cmd.clr_step || cmd.tmr_step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.req_take)
            begin
                rpt_reg <= '0;
            end
            else if ((cmd.send || (cmd.tmr_step && need_tx)) && !rpt_full)
            begin
                rpt_reg <= rpt_reg + 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.req_take)
        begin
            ack_frame_reg <= req.ack_frame;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // status
    assign sts.clr_last  = scan_reg == CW'(FRAME_COUNT_MAX - 1);
    assign sts.out_free  = out_free;
    assign sts.lu_done   = lu_reg >= nf;
    assign sts.ent_acked = ent.acked;
    assign sts.can_send  = can_send;
    assign sts.rpt_full  = rpt_full;
    assign sts.scan_done = scan_reg >= scan_end;
    assign sts.need_tx   = need_tx;

    // new frames go out in order and never move back
    a_nnf_mono: assert property (@(posedge clk) disable iff (!rst_n)
        nnf_reg >= $past(nnf_reg))
        else $error("next new frame moved backwards");

    // only sent frames can be acked
    a_acked_le_sent: assert property (@(posedge clk) disable iff (!rst_n)
        acked_reg <= nnf_reg)
        else $error("more frames acked than sent");

    // the lowest unacked frame cannot lie past the unsent ones
    a_lu_le_nnf: assert property (@(posedge clk) disable iff (!rst_n)
        lu_reg <= nnf_reg)
        else $error("window base ran past next new frame");

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("pending result overwritten");

endmodule

>>> sv/selective_repeat_sender_top.sv
// Ack transaction: the entry is read (ST_ACK_RD) and committed once the output is free
//   (ST_ACK_CHK); the result turns valid as the block is back in idle, ready again.
// Tick transaction: the base moves past acked frames (ST_BASE_RD, ST_BASE_CHK), new
//   frames in the window are sent (ST_SEND) and each frame from the base to the next new
//   frame is aged (ST_TMR_RD, ST_TMR_CHK), then done goes out; result stalls add waits.
// Reset (async, active low) clears control state, then a pass clears the frame memory.
module selective_repeat_sender_top #(
    parameter int FRAME_COUNT_MAX = 256,
    parameter int WINDOW_MAX      = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  srs_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output srs_pkg::rsp_t                  rsp,
    input  logic                           cfg_wr_en,
    input  logic [srs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    srs_pkg::cmd_t cmd;
    srs_pkg::sts_t sts;

    srs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_type (req.req_type),
        .req_ready(req_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srs_dp #(
        .FRAME_COUNT_MAX(FRAME_COUNT_MAX),
        .WINDOW_MAX     (WINDOW_MAX)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .req      (req),
        .rsp_ready(rsp_ready),
        .rsp_valid(rsp_valid),
        .rsp      (rsp),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> tb/selective_repeat_sender_top_test.sv
`timescale 1ns / 1ps

module selective_repeat_sender_top_test;

    localparam int FRAME_COUNT_MAX = 256;
    localparam int WINDOW_MAX      = 16;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_ready;
    srs_pkg::req_t                  req       = '0;
    logic                           rsp_valid;
    logic                           rsp_ready = 1'b0;
    srs_pkg::rsp_t                  rsp;
    logic                           cfg_wr_en = 1'b0;
    logic [srs_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [srs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    selective_repeat_sender_top #(
        .FRAME_COUNT_MAX(FRAME_COUNT_MAX),
        .WINDOW_MAX     (WINDOW_MAX)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // transactions waiting for the driver, results waiting for the monitor
    srs_pkg::req_t pending_reqs[$];
    srs_pkg::rsp_t expected_rsps[$];
    srs_pkg::rsp_t want_rsp;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;

    // sender state mirror
    logic [8:0] cfg_frames  = srs_pkg::FRAME_COUNT_RST;
    logic [4:0] cfg_window  = srs_pkg::WINDOW_SIZE_RST;
    logic [7:0] cfg_timeout = srs_pkg::TIMEOUT_RST;

    bit         acked_mark  [FRAME_COUNT_MAX];
    bit         sent_mark   [FRAME_COUNT_MAX];
    logic [7:0] frame_timer [FRAME_COUNT_MAX];
    logic [7:0] tx_count    [FRAME_COUNT_MAX];
    logic [8:0] next_frame  = '0;
    logic [8:0] acked_count = '0;

    initial
    begin
        for (int i = 0; i < FRAME_COUNT_MAX; i++)
        begin
            acked_mark[i]  = 1'b0;
            sent_mark[i]   = 1'b0;
            frame_timer[i] = '0;
            tx_count[i]    = '0;
        end
    end

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // sender behavior
    // ------------------------------------------------------------------

    function automatic int eff_frames();
        return (int'(cfg_frames) > FRAME_COUNT_MAX) ? FRAME_COUNT_MAX : int'(cfg_frames);
    endfunction

    // lowest unacked frame, or the frame count once all are acked
    function automatic int window_base();
        int nf;
        nf = eff_frames();
        for (int i = 0; i < nf; i++)
            if (!acked_mark[i])
                return i;
        return nf;
    endfunction

    function automatic srs_pkg::rsp_t make_rsp(logic [2:0] kind, int id, logic [7:0] cnt,
                                               logic lst);
        srs_pkg::rsp_t r;
        r.kind        = kind;
        r.frame_id    = id[7:0];
        r.send_count  = cnt;
        r.acked_total = acked_count;
        r.all_acked   = (int'(acked_count) >= eff_frames());
        r.last        = lst;
        return r;
    endfunction

    task automatic load_timer(int f);
        frame_timer[f] = cfg_timeout;
        if (tx_count[f] != 8'd255)
            tx_count[f] = tx_count[f] + 8'd1;
    endtask

    task automatic predict_results(input srs_pkg::req_t r);
        int nf;
        int w;
        int base;
        int f;
        int n;
        nf = eff_frames();
        n  = 0;
        if (r.req_type == srs_pkg::REQ_ACK)
        begin
            f = r.ack_frame;
            if (f < nf && sent_mark[f] && !acked_mark[f])
            begin
                acked_mark[f]  = 1'b1;
                frame_timer[f] = '0;
                acked_count    = acked_count + 9'd1;
                expected_rsps.push_back(make_rsp(srs_pkg::KIND_ACK_OK, f, tx_count[f], 1'b1));
            end
            else
                expected_rsps.push_back(make_rsp(srs_pkg::KIND_ACK_IGN, f, 8'd0, 1'b1));
        end
        else
        begin
            w    = (int'(cfg_window) > WINDOW_MAX) ? WINDOW_MAX : int'(cfg_window);
            base = window_base();
            // new frames inside the window
            while (int'(next_frame) < nf && int'(next_frame) < base + w)
            begin
                f            = next_frame;
                sent_mark[f] = 1'b1;
                load_timer(f);
                if (n < srs_pkg::REPORT_LIMIT)
                begin
                    expected_rsps.push_back(make_rsp(srs_pkg::KIND_SEND, f, tx_count[f], 1'b0));
                    n++;
                end
                next_frame = next_frame + 9'd1;
            end
            // age running timers, resend on expiry
            for (f = 0; f < nf; f++)
            begin
                if (sent_mark[f] && !acked_mark[f] && frame_timer[f] != 0)
                begin
                    frame_timer[f] = frame_timer[f] - 8'd1;
                    if (frame_timer[f] == 0)
                    begin
                        load_timer(f);
                        if (n < srs_pkg::REPORT_LIMIT)
                        begin
                            expected_rsps.push_back(make_rsp(srs_pkg::KIND_RETX, f,
                                                             tx_count[f], 1'b0));
                            n++;
                        end
                    end
                end
            end
            expected_rsps.push_back(make_rsp(srs_pkg::KIND_DONE, 0, 8'd0, 1'b1));
        end
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                predict_results(req);
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                    flag_mismatch($sformatf("unexpected result kind %0d frame %0d",
                                            rsp.kind, rsp.frame_id));
                else
                begin
                    want_rsp = expected_rsps.pop_front();
                    if (rsp.kind !== want_rsp.kind)
                        flag_mismatch($sformatf("kind %0d, expected %0d",
                                                rsp.kind, want_rsp.kind));
                    if (rsp.frame_id !== want_rsp.frame_id)
                        flag_mismatch($sformatf("frame_id %0d, expected %0d (kind %0d)",
                                                rsp.frame_id, want_rsp.frame_id, want_rsp.kind));
                    if (rsp.send_count !== want_rsp.send_count)
                        flag_mismatch($sformatf("send_count %0d, expected %0d (frame %0d)",
                                                rsp.send_count, want_rsp.send_count,
                                                want_rsp.frame_id));
                    if (rsp.acked_total !== want_rsp.acked_total)
                        flag_mismatch($sformatf("acked_total %0d, expected %0d",
                                                rsp.acked_total, want_rsp.acked_total));
                    if (rsp.all_acked !== want_rsp.all_acked)
                        flag_mismatch($sformatf("all_acked %0b, expected %0b",
                                                rsp.all_acked, want_rsp.all_acked));
                    if (rsp.last !== want_rsp.last)
                        flag_mismatch($sformatf("last %0b, expected %0b (kind %0d)",
                                                rsp.last, want_rsp.last, want_rsp.kind));
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_tick();
        srs_pkg::req_t r;
        r.req_type  = srs_pkg::REQ_TICK;
        r.ack_frame = 8'($urandom_range(255));
        pending_reqs.push_back(r);
    endtask

    task automatic push_ack(int id);
        srs_pkg::req_t r;
        r.req_type  = srs_pkg::REQ_ACK;
        r.ack_frame = id[7:0];
        pending_reqs.push_back(r);
    endtask

    // every transaction accepted and every result back, then a short tail
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // block must be idle here
    task automatic program_regs(logic [srs_pkg::CFG_DATA_W-1:0] fc,
                                logic [srs_pkg::CFG_DATA_W-1:0] w,
                                logic [srs_pkg::CFG_DATA_W-1:0] to);
        @(posedge clk);
        cfg_wr_en  <= 1'b1;
        cfg_addr   <= srs_pkg::REG_FRAME_COUNT;
        cfg_wdata  <= fc;
        cfg_frames  = fc[8:0];
        @(posedge clk);
        cfg_addr   <= srs_pkg::REG_WINDOW_SIZE;
        cfg_wdata  <= w;
        cfg_window  = w[4:0];
        @(posedge clk);
        cfg_addr   <= srs_pkg::REG_TIMEOUT;
        cfg_wdata  <= to;
        cfg_timeout = to[7:0];
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
    endtask

    // mostly tick-plus-acks bursts aimed at frames in flight, some noise
    task automatic run_phase(logic [srs_pkg::CFG_DATA_W-1:0] fc,
                             logic [srs_pkg::CFG_DATA_W-1:0] w,
                             logic [srs_pkg::CFG_DATA_W-1:0] to, int n_items);
        int  made;
        int  lo;
        int  hi;
        int  burst;
        bit  paused;
        made   = 0;
        paused = 1'b0;
        wait_drained();
        program_regs(fc, w, to);
        while (made < n_items)
        begin
            if (!paused && made >= n_items / 2)
            begin
                // hold off until the block has returned everything
                wait_drained();
                paused = 1'b1;
            end
            if (pending_reqs.size() < 3)
            begin
                lo = window_base();
                hi = (int'(next_frame) > 255) ? 255 : int'(next_frame);
                if ($urandom_range(99) < 75)
                begin
                    push_tick();
                    burst = $urandom_range(4);
                    for (int k = 0; k < burst; k++)
                    begin
                        if (hi > lo)
                            push_ack($urandom_range(hi, lo));
                        else
                            push_ack($urandom_range(255));
                    end
                    made += burst + 1;
                end
                else
                begin
                    if ($urandom_range(1) == 1)
                        push_tick();
                    else
                        push_ack($urandom_range(255));
                    made++;
                end
            end
            else
                @(posedge clk);
        end
    endtask

    initial
    begin
        send_idle_pct = 34;
        recv_idle_pct = 60;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: first window, duplicate, unsent and out-of-range acks
        push_tick();
        push_ack(0);
        push_ack(0);
        push_ack(6);
        push_ack(255);
        push_tick();
        repeat (4) push_tick();
        push_ack(1);
        push_ack(2);
        push_ack(3);
        push_ack(4);
        push_tick();
        wait_drained();

        // zero frame count, zero window, zero timeout
        program_regs(9'd0, 9'd0, 9'd0);
        push_tick();
        push_ack(0);
        push_ack(255);
        wait_drained();

        // oversized frame count and window, timeout of one: report overflow
        program_regs(9'd511, 9'd31, 9'd1);
        push_tick();
        push_tick();
        push_ack(255);
        push_ack(5);
        push_tick();
        wait_drained();

        // timeout zero with new frames, largest timeout
        program_regs(9'd256, 9'd16, 9'd0);
        push_tick();
        push_ack(8);
        push_tick();
        wait_drained();
        program_regs(9'd256, 9'd16, 9'd255);
        push_tick();

        // random phases
        run_phase(9'd24, 9'd4, 9'd3, 60);
        run_phase(9'd40, 9'd1, 9'd2, 60);
        run_phase(9'd64, 9'd16, 9'd6, 60);
        send_idle_pct = 60;
        recv_idle_pct = 34;
        run_phase(9'd100, 9'd7, 9'd1, 60);
        run_phase(9'd160, 9'd31, 9'd4, 60);
        run_phase(9'd200, 9'd10, 9'd255, 60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(9'd256, 9'd16, 9'd2, 60);
        run_phase(9'd300, 9'd3, 9'd1, 60);

        wait_drained();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
